@@ design/sdac_pkg.sv @@
// ----------------------------------------------------------------------------
// sdac_pkg
// Shared sizes, character codes and state type of the signed decimal
// ascii converter.
// ----------------------------------------------------------------------------
package sdac_pkg;

    // width of the value field
    localparam int VALUE_BITS = 32;

    // decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1)
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    // bit counter of the conversion and digit counter of the emitter
    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(DIGITS + 1);

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;

    // output modes
    localparam logic MODE_INT   = 1'b0;
    localparam logic MODE_TENTH = 1'b1;

    typedef logic [DIGITS-1:0][3:0] bcd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage

@@ design/signed_decimal_ascii_converter_top.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_ascii_converter_top
// Prints a signed value as decimal ascii characters, most significant first,
// as an integer or as tenths with one fraction digit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_mode, s_value
//  m_       out  m_valid / m_ready  m_char_code, m_last
//
// A word is taken only in idle. The magnitude is converted bit-serially,
// leading zeros are dropped at one digit per cycle (up to DIGITS - 1) plus a
// check that finds the first kept digit, then one character leaves per cycle
// while m_ready allows, up to 12 for 32 bits. Reset clears all control state.
// A stall on m_ stops the emitter; the output register lets the next word in
// while the final character still waits.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_converter_top
    import sdac_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic signed [VALUE_BITS-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_char_code,
    output logic                         m_last
);

    state_t                state_reg, state_next;
    logic                  mode_reg, neg_reg;
    bcd_t                  bcd_reg;
    logic [DIG_CNT_W-1:0]  count_reg;
    logic                  sign_pend_reg, dot_done_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_char_reg, m_char_next;
    logic                  m_last_reg, m_last_next;

    logic                  accept;
    logic [VALUE_BITS-1:0] val_u, mag;
    logic                  dab_done;
    bcd_t                  dab_bcd;
    logic [DIG_CNT_W-1:0]  min_cnt;
    logic                  skip_ok, can_load;
    logic                  emit_sign, emit_dot, emit_digit, emit_final;

    // input side and magnitude
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign val_u   = s_value;
    assign mag     = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;

    sdac_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (mag),
        .done    (dab_done),
        .bcd     (dab_bcd)
    );

    // leading zero skip and character selection
    assign min_cnt    = (mode_reg == MODE_TENTH) ? DIG_CNT_W'(2) : DIG_CNT_W'(1);
    assign skip_ok    = (bcd_reg[DIGITS-1] == 4'd0) && (count_reg > min_cnt);
    assign can_load   = !m_valid_reg || m_ready;
    assign emit_sign  = (state_reg == ST_EMIT) && can_load && sign_pend_reg;
    assign emit_dot   = (state_reg == ST_EMIT) && can_load && !sign_pend_reg
                        && (mode_reg == MODE_TENTH) && (count_reg == DIG_CNT_W'(1))
                        && !dot_done_reg;
    assign emit_digit = (state_reg == ST_EMIT) && can_load && !emit_sign && !emit_dot;
    assign emit_final = emit_digit && (count_reg == DIG_CNT_W'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)      state_next = ST_CONV;
            ST_CONV: if (dab_done)    state_next = ST_SKIP;
            ST_SKIP: if (!skip_ok)    state_next = ST_EMIT;
            ST_EMIT: if (emit_final)  state_next = ST_IDLE;
            default:                  state_next = ST_IDLE;
        endcase
    end

    // output word
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        priority if (emit_sign) begin
            m_valid_next = 1'b1;
            m_char_next  = CH_MINUS;
            m_last_next  = 1'b0;
        end else if (emit_dot) begin
            m_valid_next = 1'b1;
            m_char_next  = CH_DOT;
            m_last_next  = 1'b0;
        end else if (emit_digit) begin
            m_valid_next = 1'b1;
            m_char_next  = CH_ZERO + {4'd0, bcd_reg[DIGITS-1]};
            m_last_next  = emit_final;
        end else begin
            m_valid_next = m_valid_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            count_reg     <= '0;
            sign_pend_reg <= 1'b0;
            dot_done_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CONV && dab_done) begin
                count_reg     <= DIG_CNT_W'(DIGITS);
                sign_pend_reg <= neg_reg;
                dot_done_reg  <= 1'b0;
            end else if (state_reg == ST_SKIP && skip_ok) begin
                count_reg <= count_reg - DIG_CNT_W'(1);
            end else if (emit_digit) begin
                count_reg <= count_reg - DIG_CNT_W'(1);
            end
            if (emit_sign) begin
                sign_pend_reg <= 1'b0;
            end
            if (emit_dot) begin
                dot_done_reg <= 1'b1;
            end
        end
    end

    // data registers
    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (accept) begin
            mode_reg <= s_mode;
            neg_reg  <= val_u[VALUE_BITS-1];
        end
        if (state_reg == ST_CONV && dab_done) begin
            bcd_reg <= dab_bcd;
        end else if ((state_reg == ST_SKIP && skip_ok) || emit_digit) begin
            bcd_reg <= bcd_t'({bcd_reg[DIGITS-2:0], 4'd0});
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

    // conversion finishes only while waiting for it
    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_done |-> state_reg == ST_CONV)
        else $error("conversion done outside conversion state");

    // the emitter always has a digit left
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> count_reg != '0)
        else $error("digit count empty while emitting");

    // zero skipping never goes below the minimum digit count
    a_skip_min: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SKIP |-> count_reg >= min_cnt)
        else $error("too many leading digits dropped");

    // only digits, minus and dot leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_char_reg >= CH_ZERO && m_char_reg <= CH_ZERO + 8'd9)
                        || m_char_reg == CH_MINUS || m_char_reg == CH_DOT)
        else $error("illegal character code");

endmodule

@@ design/sdac_dabble.sv @@
// ----------------------------------------------------------------------------
// sdac_dabble
// Bit-serial binary to bcd conversion: one magnitude bit shifted in per
// cycle, every digit corrected by add-3 before the shift.
// ----------------------------------------------------------------------------
module sdac_dabble
    import sdac_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] mag,
    output logic                  done,
    output bcd_t                  bcd
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    bcd_t                  bcd_reg, bcd_next;
    bcd_t                  adj;

    // add-3 correction of each digit
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    // shift one bit per cycle until all bits are in
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = BIT_CNT_W'(VALUE_BITS);
            shift_next = mag;
            bcd_next   = '0;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
            bcd_next   = bcd_t'({adj[DIGITS-1][2:0], adj[DIGITS-2:0],
                                 shift_reg[VALUE_BITS-1]});
            cnt_next   = cnt_reg - BIT_CNT_W'(1);
            if (cnt_reg == BIT_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

    // a conversion is never restarted while one is running
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("conversion restarted while busy");

    // done follows the final shift
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && cnt_reg == '0)
        else $error("done without finished conversion");

    // counter stays in range
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= BIT_CNT_W'(VALUE_BITS))
        else $error("bit counter out of range");

endmodule

@@ tb/signed_decimal_ascii_converter_top_tb.sv @@
// ----------------------------------------------------------------------------
// signed_decimal_ascii_converter_top_tb
// Drives signed values in integer and tenths mode into the converter. Each
// accepted word is expanded into its expected ascii characters. Every
// character that leaves the block is compared with the oldest one still
// pending. The sender works in bursts and the receiver stalls, both with
// styles that change from phase to phase.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_converter_top_tb
    import sdac_pkg::*;
();

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 80;
    localparam int DRAIN_CYCLES = 80;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } ascii_char_t;

    // expected text of every accepted word, one character per entry
    class ascii_scoreboard;
        ascii_char_t pending_chars[$];
        int errors;
        int words;
        int tenth_words;
        int neg_words;
        int chars;

        function void note_word(logic mode, value_t value);
            logic [VALUE_BITS-1:0] mag;
            logic [7:0]            digit;
            logic [7:0]            text[$];
            ascii_char_t           ch;
            logic                  neg;
            neg = value[VALUE_BITS-1];
            mag = value;
            if (neg) begin
                mag = -mag;
            end
            // fraction digit and point come first when reading tenths
            if (mode == MODE_TENTH) begin
                digit = 8'(mag % 10);
                text.push_front(CH_ZERO + digit);
                text.push_front(CH_DOT);
                mag = mag / 10;
            end
            // integer digits, at least one
            do begin
                digit = 8'(mag % 10);
                text.push_front(CH_ZERO + digit);
                mag = mag / 10;
            end while (mag != 0);
            if (neg) begin
                text.push_front(CH_MINUS);
            end
            foreach (text[k]) begin
                ch.code = text[k];
                ch.last = (k == text.size() - 1);
                pending_chars.push_back(ch);
            end
            words++;
            if (mode == MODE_TENTH) tenth_words++;
            if (neg) neg_words++;
        endfunction

        function void check_char(logic [7:0] code, logic last);
            ascii_char_t want;
            if (pending_chars.size() == 0) begin
                $error("character 0x%02h (last %0b) with no word pending", code, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            chars++;
            if (code !== want.code) begin
                $error("char_code: expected 0x%02h, got 0x%02h", want.code, code);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int waiting();
            return pending_chars.size();
        endfunction
    endclass

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    logic   s_mode;
    value_t s_value;
    logic   m_valid;
    logic   m_ready;
    logic [7:0] m_char_code;
    logic   m_last;

    ascii_scoreboard sb = new();
    int pace;
    int idle_cycles;

    signed_decimal_ascii_converter_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // offer one word and hold it until taken; returns at a falling edge
    task automatic send_word(input logic mode, input value_t value);
        s_valid = 1'b1;
        s_mode  = mode;
        s_value = value;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(mode, value);
        @(negedge aclk);
    endtask

    // random value with a spread of magnitudes and the usual edges
    function automatic value_t pick_value();
        longint p;
        value_t v;
        case ($urandom_range(0, 5))
            0: v = value_t'($urandom());
            1: v = $signed($urandom_range(0, 200)) - 100;
            2: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = value_t'(p + $signed($urandom_range(0, 2)) - 1);
                if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
                v = {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 3);
                if ($urandom_range(0, 1)) v = ~v;
            end
            4: v = $signed($urandom_range(0, 18)) - 9;
            default: begin
                v = value_t'($urandom());
                v = v >>> $urandom_range(0, VALUE_BITS - 1);
            end
        endcase
        return v;
    endfunction

    // receiver: ready pattern depends on the current pace
    initial begin
        int stall_left;
        logic [7:0] pattern;
        stall_left = 0;
        pattern = 8'b1011_0110;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                case (pace)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    2: begin
                        if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 20);
                            m_ready = 1'b0;
                        end else begin
                            m_ready = 1'b1;
                        end
                    end
                    default: begin
                        pattern = {pattern[6:0], pattern[7]};
                        m_ready = pattern[0];
                    end
                endcase
            end
        end
    end

    // compare every character that leaves the block
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_char_code, m_last);
        end
    end

    // cycles in a row with no word moving on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial begin
        do @(posedge aclk); while (idle_cycles < IDLE_LIMIT);
        $display("no progress for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int burst_left;
        int gap;
        logic mode;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode  = MODE_INT;
        s_value = '0;
        pace    = 1;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero, one digit, tenths below one, sign, extremes
        send_word(MODE_INT,   0);
        send_word(MODE_TENTH, 0);
        send_word(MODE_INT,   1);
        send_word(MODE_TENTH, 1);
        send_word(MODE_INT,   -1);
        send_word(MODE_TENTH, -1);
        send_word(MODE_TENTH, -5);
        send_word(MODE_TENTH, -9);
        send_word(MODE_TENTH, 9);
        send_word(MODE_TENTH, 10);
        send_word(MODE_TENTH, -10);
        send_word(MODE_INT,   9);
        send_word(MODE_INT,   10);
        send_word(MODE_INT,   -10);
        send_word(MODE_INT,   {1'b0, {(VALUE_BITS-1){1'b1}}});
        send_word(MODE_INT,   {1'b1, {(VALUE_BITS-1){1'b0}}});
        send_word(MODE_TENTH, {1'b0, {(VALUE_BITS-1){1'b1}}});
        send_word(MODE_TENTH, {1'b1, {(VALUE_BITS-1){1'b0}}});
        send_word(MODE_INT,   {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1});
        send_word(MODE_INT,   1000000000);
        send_word(MODE_TENTH, -12345);
        send_word(MODE_INT,   {VALUE_BITS/2{2'b10}});
        send_word(MODE_TENTH, {VALUE_BITS/2{2'b01}});

        // random words in four phases of different pacing
        burst_left = 0;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pace = (i * 4) / RANDOM_WORDS;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 6);
                if (pace != 0) begin
                    gap = (pace == 2) ? $urandom_range(1, 60) : $urandom_range(0, 12);
                    if (gap > 0) begin
                        s_valid = 1'b0;
                        repeat (gap) @(negedge aclk);
                    end
                end
            end
            burst_left--;
            mode = 1'($urandom_range(0, 1));
            send_word(mode, pick_value());
        end
        s_valid = 1'b0;

        // drain
        while (sb.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words converted (%0d in tenths, %0d negative), %0d characters checked",
                 sb.words, sb.tenth_words, sb.neg_words, sb.chars);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/sdac_pkg.sv
design/sdac_dabble.sv
design/signed_decimal_ascii_converter_top.sv
tb/signed_decimal_ascii_converter_top_tb.sv
